>>> src/hmq_pkg.sv
package hmq_pkg;

   localparam int unsigned HMQ_CAPACITY = 64;
   localparam int unsigned KEY_WIDTH = 32;
   localparam int unsigned PAYLOAD_WIDTH = 32;
   localparam int unsigned COUNT_WIDTH = 7;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_EXTRACT = 2'd1;
   localparam logic [1:0] ACT_PEEK = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]               action;
      logic [KEY_WIDTH-1:0]     key;
      logic [PAYLOAD_WIDTH-1:0] payload;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [KEY_WIDTH-1:0]     out_key;
      logic [PAYLOAD_WIDTH-1:0] out_payload;
      logic [COUNT_WIDTH-1:0]   count;
      logic                     is_empty;
   } rsp_beat_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0]     key;
      logic [PAYLOAD_WIDTH-1:0] payload;
   } entry_type;

   // operands of the shared compare unit
   typedef struct packed {
      logic                 down;
      logic [KEY_WIDTH-1:0] mov_key;
      logic [KEY_WIDTH-1:0] a_key;
      logic [KEY_WIDTH-1:0] b_key;
      logic                 b_ok;
   } cmp_req_type;

   typedef struct packed {
      logic take_b;
      logic move;
   } cmp_result_type;

endpackage

>>> src/hmq_store.sv
module hmq_store #(
   parameter int unsigned DEPTH = hmq_pkg::HMQ_CAPACITY,
   localparam int unsigned IDX_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  hmq_pkg::entry_type  wr_data,
   input  logic [IDX_W-1:0]    rd_addr_a,
   input  logic [IDX_W-1:0]    rd_addr_b,
   output hmq_pkg::entry_type  rd_data_a,
   output hmq_pkg::entry_type  rd_data_b
);
   import hmq_pkg::*;

   entry_type slot_mem [DEPTH];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= slot_mem[rd_addr_a];
      rd_b_ff <= slot_mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> src/hmq_cmp.sv
module hmq_cmp (
   input  hmq_pkg::cmp_req_type    cmp_req,
   output hmq_pkg::cmp_result_type cmp_res
);
   import hmq_pkg::*;

   logic m_lt_a;
   logic a_lt_m;
   logic b_lt_m;
   logic b_lt_a;

   always_comb begin
      m_lt_a = cmp_req.mov_key < cmp_req.a_key;
      a_lt_m = cmp_req.a_key < cmp_req.mov_key;
      b_lt_m = cmp_req.b_key < cmp_req.mov_key;
      // left child wins a tie
      b_lt_a = cmp_req.b_ok && (cmp_req.b_key < cmp_req.a_key);
      if (cmp_req.down) begin
         cmp_res.take_b = b_lt_a;
         cmp_res.move = b_lt_a ? b_lt_m : a_lt_m;
      end else begin
         cmp_res.take_b = 1'b0;
         cmp_res.move = m_lt_a;
      end
   end

endmodule

>>> src/binary_min_heap_queue_core.sv
// Min-heap priority queue of CAPACITY (key, payload) entries, smallest key served first.
// Raise start with an insert, extract-min or peek on req_data while busy is low; exactly
// one result follows on rsp_data, marked by a single-cycle rsp_valid that cannot be held
// off, so capture it when it shows. Full-insert, first-entry insert and empty-heap requests
// answer in the cycle after start, a peek reads the root in ST_PEEK, any other insert lifts
// the entry one level per ST_UP step, and an extract takes the root in ST_TAKE and, unless
// at most one entry remains, sinks the last entry one level per ST_DOWN step. A walk that
// reaches the root or a leaf ends in ST_PLACE. The entry memory moves one entry per cycle
// through its single write port while its two read ports fetch the next parent or both
// children for the shared compare unit. Entries are held without reset; only occupied slots' data is used.
module binary_min_heap_queue_core #(
   parameter int unsigned CAPACITY = hmq_pkg::HMQ_CAPACITY
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  hmq_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   output hmq_pkg::rsp_beat_type rsp_data
);
   import hmq_pkg::*;

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CW = IDX_W + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP,
      ST_TAKE,
      ST_DOWN,
      ST_PLACE,
      ST_PEEK
   } state_type;

   state_type      state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] pos_ff;
   logic           hi_ok_ff;
   entry_type      mov_ff;
   logic           rsp_valid_ff;
   rsp_beat_type   rsp_ff;

   logic           wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type      wr_data;
   logic [IDX_W-1:0] rd_addr_a;
   logic [IDX_W-1:0] rd_addr_b;
   entry_type      rd_a;
   entry_type      rd_b;

   cmp_req_type    cmp_req;
   cmp_result_type cres;

   logic [IDX_W-1:0] par_idx;
   logic [IDX_W-1:0] gpar_idx;
   logic [CW-1:0]  lo_c;
   logic [CW-1:0]  hi_c;
   logic [CW-1:0]  best_c;
   logic [IDX_W-1:0] best_idx;
   logic [CW-1:0]  nlo_c;
   logic [CW-1:0]  nhi_c;
   logic [CW-1:0]  cnt_c;
   logic           nlo_ok;
   logic           nhi_ok;
   logic           heap_full;
   logic           heap_none;

   hmq_store #(
      .DEPTH(CAPACITY)
   ) u_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_a(rd_a),
      .rd_data_b(rd_b)
   );

   hmq_cmp u_cmp (
      .cmp_req(cmp_req),
      .cmp_res(cres)
   );

   always_comb begin
      heap_full = (count_ff == CNT_W'(CAPACITY));
      heap_none = (count_ff == '0);
      par_idx = (pos_ff - IDX_W'(1)) >> 1;
      gpar_idx = (par_idx - IDX_W'(1)) >> 1;
      lo_c = {1'b0, pos_ff, 1'b1};
      hi_c = lo_c + CW'(1);
      best_c = cres.take_b ? hi_c : lo_c;
      best_idx = best_c[IDX_W-1:0];
      nlo_c = {1'b0, best_idx, 1'b1};
      nhi_c = nlo_c + CW'(1);
      cnt_c = CW'(count_ff);
      nlo_ok = nlo_c < cnt_c;
      nhi_ok = nhi_c < cnt_c;

      cmp_req.down = (state_ff == ST_DOWN);
      cmp_req.mov_key = mov_ff.key;
      cmp_req.a_key = rd_a.key;
      cmp_req.b_key = rd_b.key;
      cmp_req.b_ok = hi_ok_ff;

      wr_en = 1'b0;
      wr_addr = pos_ff;
      wr_data = mov_ff;
      rd_addr_a = '0;
      rd_addr_b = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.action)
                  ACT_INSERT: begin
                     if (heap_none) begin
                        wr_en = 1'b1;
                        wr_addr = '0;
                        wr_data = '{key: req_data.key, payload: req_data.payload};
                     end else begin
                        rd_addr_a = IDX_W'((count_ff - CNT_W'(1)) >> 1);
                     end
                  end
                  ACT_EXTRACT: begin
                     rd_addr_a = '0;
                     rd_addr_b = IDX_W'(count_ff - CNT_W'(1));
                  end
                  default: begin
                     rd_addr_a = '0;
                  end
               endcase
            end
         end
         ST_UP: begin
            wr_en = 1'b1;
            if (cres.move) begin
               wr_data = rd_a;
               rd_addr_a = gpar_idx;
            end
         end
         ST_TAKE: begin
            // count already holds the post-extract value
            if (count_ff == CNT_W'(1)) begin
               wr_en = 1'b1;
               wr_addr = '0;
               wr_data = rd_b;
            end else begin
               rd_addr_a = IDX_W'(1);
               rd_addr_b = IDX_W'(2);
            end
         end
         ST_DOWN: begin
            wr_en = 1'b1;
            if (cres.move) begin
               wr_data = cres.take_b ? rd_b : rd_a;
               rd_addr_a = nlo_c[IDX_W-1:0];
               rd_addr_b = nhi_c[IDX_W-1:0];
            end
         end
         ST_PLACE: begin
            wr_en = 1'b1;
         end
         ST_PEEK: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  rsp_ff.out_key <= '0;
                  rsp_ff.out_payload <= '0;
                  mov_ff <= '{key: req_data.key, payload: req_data.payload};
                  unique case (req_data.action)
                     ACT_INSERT: begin
                        if (heap_full) begin
                           rsp_ff.status <= ST_FULL;
                           rsp_ff.count <= COUNT_WIDTH'(count_ff);
                           rsp_ff.is_empty <= 1'b0;
                           rsp_valid_ff <= 1'b1;
                        end else if (heap_none) begin
                           rsp_ff.status <= ST_OK;
                           count_ff <= CNT_W'(1);
                           rsp_ff.count <= COUNT_WIDTH'(1);
                           rsp_ff.is_empty <= 1'b0;
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           rsp_ff.status <= ST_OK;
                           count_ff <= count_ff + CNT_W'(1);
                           pos_ff <= IDX_W'(count_ff);
                           state_ff <= ST_UP;
                        end
                     end
                     ACT_EXTRACT: begin
                        if (heap_none) begin
                           rsp_ff.status <= ST_EMPTY;
                           rsp_ff.count <= '0;
                           rsp_ff.is_empty <= 1'b1;
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           rsp_ff.status <= ST_OK;
                           count_ff <= count_ff - CNT_W'(1);
                           state_ff <= ST_TAKE;
                        end
                     end
                     default: begin
                        if (heap_none) begin
                           rsp_ff.status <= ST_EMPTY;
                           rsp_ff.count <= '0;
                           rsp_ff.is_empty <= 1'b1;
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           rsp_ff.status <= ST_OK;
                           state_ff <= ST_PEEK;
                        end
                     end
                  endcase
               end
            end
            ST_UP: begin
               if (cres.move) begin
                  pos_ff <= par_idx;
                  if (par_idx == '0) begin
                     state_ff <= ST_PLACE;
                  end
               end else begin
                  rsp_ff.count <= COUNT_WIDTH'(count_ff);
                  rsp_ff.is_empty <= heap_none;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            ST_TAKE: begin
               rsp_ff.out_key <= rd_a.key;
               rsp_ff.out_payload <= rd_a.payload;
               mov_ff <= rd_b;
               pos_ff <= '0;
               hi_ok_ff <= (count_ff > CNT_W'(2));
               if (count_ff <= CNT_W'(1)) begin
                  rsp_ff.count <= COUNT_WIDTH'(count_ff);
                  rsp_ff.is_empty <= heap_none;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_DOWN;
               end
            end
            ST_DOWN: begin
               if (cres.move) begin
                  pos_ff <= best_idx;
                  hi_ok_ff <= nhi_ok;
                  state_ff <= nlo_ok ? ST_DOWN : ST_PLACE;
               end else begin
                  rsp_ff.count <= COUNT_WIDTH'(count_ff);
                  rsp_ff.is_empty <= heap_none;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            ST_PLACE: begin
               rsp_ff.count <= COUNT_WIDTH'(count_ff);
               rsp_ff.is_empty <= heap_none;
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            ST_PEEK: begin
               rsp_ff.out_key <= rd_a.key;
               rsp_ff.out_payload <= rd_a.payload;
               rsp_ff.count <= COUNT_WIDTH'(count_ff);
               rsp_ff.is_empty <= heap_none;
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_rsp_only_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE)
      else $error("result beat while an operation is in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.action == ACT_INSERT && heap_full
      |=> rsp_valid_ff && rsp_ff.status == ST_FULL && $stable(count_ff))
      else $error("insert into full heap not rejected");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.is_empty == (count_ff == '0))
      else $error("empty flag disagrees with count");

   a_walk_writes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DOWN || state_ff == ST_UP) |-> wr_en && CW'(pos_ff) < cnt_c)
      else $error("heap walk outside occupied slots");

endmodule
